/* rtl/rav_pkg.sv */
// Shared sizes, codes and transfer types of the running average window block.
package rav_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int OP_W        = 2;
    localparam int FILL_W      = 8;
    localparam int CFG_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0]    CFG_RESET = CFG_W'(3);
    localparam logic [SUM_W-1:0]    POS_LIM   = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic [SUM_W-1:0]    NEG_LIM   = SUM_W'(2 ** (SAMPLE_W - 1));
    localparam logic [SAMPLE_W-1:0] AVG_MAX   = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] AVG_MIN   = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FILL  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_CLEAR,
        CMD_FILL,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [SAMPLE_W-1:0] sample;
        logic [FILL_W-1:0]   fill_count;
    } t_cmd;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/rav_front.sv */
// Input stage: takes a transaction and decodes it into an internal command.
module rav_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [rav_pkg::OP_W-1:0]           i_op,
    input  logic signed [rav_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [rav_pkg::FILL_W-1:0]         i_fill_count,
    output logic                               o_cmd_valid,
    input  logic                               i_cmd_ready,
    output rav_pkg::t_cmd                      o_cmd
);

    logic          r_valid;
    rav_pkg::t_cmd r_cmd;
    rav_pkg::t_cmd w_cmd;

    always_comb begin
        w_cmd.kind       = rav_pkg::CMD_NOP;
        w_cmd.sample     = i_sample;
        w_cmd.fill_count = i_fill_count;
        unique case (rav_pkg::t_op'(i_op))
            rav_pkg::OP_ADD:   w_cmd.kind = rav_pkg::CMD_ADD;
            rav_pkg::OP_CLEAR: w_cmd.kind = rav_pkg::CMD_CLEAR;
            // an empty fill is just a clear
            rav_pkg::OP_FILL:  w_cmd.kind = (i_fill_count == '0) ? rav_pkg::CMD_CLEAR
                                                                : rav_pkg::CMD_FILL;
            rav_pkg::OP_NOP:   w_cmd.kind = rav_pkg::CMD_NOP;
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

/* rtl/rav_queue.sv */
// Small command queue between the decode stage and the execution unit.
module rav_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  rav_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output rav_pkg::t_cmd o_pop_cmd
);

    localparam int PTR_W = (rav_pkg::QUEUE_DEPTH > 1) ? $clog2(rav_pkg::QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(rav_pkg::QUEUE_DEPTH + 1);

    rav_pkg::t_cmd    r_mem [rav_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [LVL_W-1:0] r_level;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_level != LVL_W'(rav_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_level != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(rav_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(rav_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_level <= r_level + 1'b1;
            end else if (w_pop && !w_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

/* rtl/rav_div.sv */
// Bit-serial signed divider of the running sum by the sample count, with saturation.
module rav_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rav_pkg::t_div_req i_req,
    output rav_pkg::t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(rav_pkg::SUM_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIN
    } t_state;

    t_state                       r_state;
    logic [STEP_W-1:0]            r_step;
    logic [rav_pkg::SUM_W-1:0]    r_quo;
    logic [rav_pkg::CNT_W-1:0]    r_rem;
    logic [rav_pkg::CNT_W-1:0]    r_div;
    logic                         r_neg;
    logic                         r_done;
    logic [rav_pkg::SAMPLE_W-1:0] r_q;

    logic [rav_pkg::CNT_W:0]      w_trial;
    logic                         w_ge;
    logic [rav_pkg::CNT_W-1:0]    w_rem_nxt;
    logic [rav_pkg::CNT_W:0]      w_diff;
    logic [rav_pkg::SUM_W-1:0]    w_negq;
    logic [rav_pkg::SUM_W-1:0]    w_abs;
    logic [rav_pkg::SAMPLE_W-1:0] w_q_fin;

    assign w_trial   = {r_rem, r_quo[rav_pkg::SUM_W-1]};
    assign w_ge      = (w_trial >= {1'b0, r_div});
    assign w_diff    = w_trial - {1'b0, r_div};
    assign w_rem_nxt = w_ge ? w_diff[rav_pkg::CNT_W-1:0] : w_trial[rav_pkg::CNT_W-1:0];
    assign w_negq    = ~r_quo + 1'b1;
    assign w_abs     = i_req.dividend[rav_pkg::SUM_W-1] ? (~i_req.dividend + 1'b1)
                                                        : i_req.dividend;

    // apply sign and clamp to the sample range
    always_comb begin
        w_q_fin = '0;
        if (r_div == '0) begin
            w_q_fin = '0;
        end else if (!r_neg) begin
            w_q_fin = (r_quo > rav_pkg::POS_LIM) ? rav_pkg::AVG_MAX
                                                 : r_quo[rav_pkg::SAMPLE_W-1:0];
        end else begin
            w_q_fin = (r_quo > rav_pkg::NEG_LIM) ? rav_pkg::AVG_MIN
                                                 : w_negq[rav_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_neg   <= i_req.dividend[rav_pkg::SUM_W-1];
                        r_quo   <= w_abs;
                        r_rem   <= '0;
                        r_div   <= i_req.divisor;
                        r_step  <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    // shift in one dividend bit, retire one quotient bit
                    r_rem <= w_rem_nxt;
                    r_quo <= {r_quo[rav_pkg::SUM_W-2:0], w_ge};
                    if (r_step == STEP_W'(rav_pkg::SUM_W - 1)) begin
                        r_state <= D_FIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                D_FIN: begin
                    r_q     <= w_q_fin;
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

/* rtl/rav_exec.sv */
// Execution unit: sample ring, running sum, count, fill sequencer and result register.
module rav_exec (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  rav_pkg::t_cmd                i_cmd,
    input  logic [rav_pkg::CFG_W-1:0]    i_window_size,
    output rav_pkg::t_div_req            o_div_req,
    input  rav_pkg::t_div_rsp            i_div_rsp,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rav_pkg::SAMPLE_W-1:0] o_average,
    output logic [rav_pkg::CNT_W-1:0]    o_count
);

    localparam int CMP_W = rav_pkg::CNT_W + rav_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_FILL,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

    t_state                       r_state;
    rav_pkg::t_cmd                r_cmd;
    logic [rav_pkg::SUM_W-1:0]    r_sum;
    logic [rav_pkg::IDX_W-1:0]    r_widx;
    logic [rav_pkg::CNT_W-1:0]    r_cnt;
    logic [rav_pkg::WINDOW_MAX-1:0] r_vld;
    logic [rav_pkg::SAMPLE_W-1:0] r_ring [rav_pkg::WINDOW_MAX];
    logic [rav_pkg::SAMPLE_W-1:0] r_rd_data;
    logic [rav_pkg::FILL_W-1:0]   r_left;
    logic [rav_pkg::SAMPLE_W-1:0] r_res_avg;
    logic                         r_ovalid;
    logic [rav_pkg::SAMPLE_W-1:0] r_oavg;
    logic [rav_pkg::CNT_W-1:0]    r_ocnt;

    logic [rav_pkg::CNT_W-1:0]    w_win;
    logic [rav_pkg::SAMPLE_W-1:0] w_old;
    logic [rav_pkg::SUM_W-1:0]    w_old_ext;
    logic [rav_pkg::SUM_W-1:0]    w_new_ext;
    logic [rav_pkg::SUM_W-1:0]    w_sum_nxt;
    logic [rav_pkg::CNT_W:0]      w_nxt;
    logic [rav_pkg::IDX_W-1:0]    w_widx_nxt;
    logic [rav_pkg::CNT_W-1:0]    w_cnt_nxt;
    logic                         w_write;

    // clamp the window to 1..WINDOW_MAX
    always_comb begin
        w_win = rav_pkg::CNT_W'(i_window_size);
        if (i_window_size == '0) begin
            w_win = rav_pkg::CNT_W'(1);
        end else if (CMP_W'(i_window_size) > CMP_W'(rav_pkg::WINDOW_MAX)) begin
            w_win = rav_pkg::CNT_W'(rav_pkg::WINDOW_MAX);
        end
    end

    // during a fill every live entry already holds the fill value
    always_comb begin
        w_old = '0;
        if (r_vld[r_widx]) begin
            w_old = (r_state == S_FILL) ? r_cmd.sample : r_rd_data;
        end
    end

    assign w_old_ext  = {{(rav_pkg::SUM_W - rav_pkg::SAMPLE_W){w_old[rav_pkg::SAMPLE_W-1]}},
                         w_old};
    assign w_new_ext  = {{(rav_pkg::SUM_W - rav_pkg::SAMPLE_W){r_cmd.sample[rav_pkg::SAMPLE_W-1]}},
                         r_cmd.sample};
    assign w_sum_nxt  = r_sum - w_old_ext + w_new_ext;
    assign w_nxt      = (rav_pkg::CNT_W + 1)'(r_widx) + (rav_pkg::CNT_W + 1)'(1);
    assign w_widx_nxt = (w_nxt >= {1'b0, w_win}) ? '0 : w_nxt[rav_pkg::IDX_W-1:0];
    assign w_cnt_nxt  = (r_cnt < w_win) ? r_cnt + 1'b1 : w_win;
    assign w_write    = (r_state == S_UPD) || (r_state == S_FILL);

    assign o_cmd_ready        = (r_state == S_IDLE);
    assign o_div_req.start    = (r_state == S_DSTART);
    assign o_div_req.dividend = r_sum;
    assign o_div_req.divisor  = r_cnt;
    assign o_valid            = r_ovalid;
    assign o_average          = r_oavg;
    assign o_count            = r_ocnt;

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_ring[r_widx] <= r_cmd.sample;
        end
        r_rd_data <= r_ring[r_widx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sum    <= '0;
            r_widx   <= '0;
            r_cnt    <= '0;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_write) begin
                r_vld[r_widx] <= 1'b1;
                r_sum         <= w_sum_nxt;
                r_widx        <= w_widx_nxt;
                r_cnt         <= w_cnt_nxt;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.kind)
                            rav_pkg::CMD_ADD: r_state <= S_UPD;
                            rav_pkg::CMD_CLEAR: begin
                                r_vld   <= '0;
                                r_sum   <= '0;
                                r_widx  <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DSTART;
                            end
                            rav_pkg::CMD_FILL: begin
                                r_vld   <= '0;
                                r_sum   <= '0;
                                r_widx  <= '0;
                                r_cnt   <= '0;
                                r_left  <= i_cmd.fill_count;
                                r_state <= S_FILL;
                            end
                            rav_pkg::CMD_NOP: r_state <= S_DSTART;
                        endcase
                    end
                end
                S_UPD: r_state <= S_DSTART;
                S_FILL: begin
                    r_left <= r_left - 1'b1;
                    if (r_left == rav_pkg::FILL_W'(1)) begin
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: r_state <= S_DIV;
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_res_avg <= i_div_rsp.quotient;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the result until the output register frees up
                    if (!r_ovalid || i_ready) begin
                        r_oavg   <= r_res_avg;
                        r_ocnt   <= r_cnt;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/running_average_window_core.sv */
// Top level of the running average window block.
//
// Channels: an input channel (i_valid/o_ready) carries op, sample and fill_count;
// an output channel (o_valid/i_ready) returns average and count, one result per
// input transaction, in order. A separate write channel (i_cfg_valid/o_cfg_ready)
// loads window_size; write it only while the block is idle, then issue a clear.
// Op add replaces the oldest entry, clear empties the window, fill clears and then
// adds the sample fill_count times; op three only reports the current state.
//
// The time from acceptance to the result is set by the bit-serial divider (one quotient
// bit per cycle over the 22-bit sum) and, for fill, by the one-write-per-cycle sample
// ring. Items are executed one at a time: the next command is not taken until the
// result of the last one has moved into the output register; a two-entry queue and the
// input stage keep taking transactions meanwhile.
//
// Reset (synchronous, active low) empties the window and sets window_size to 3.
// If the receiver stalls, the result is held in the output register; execution of
// the next item stops before it would overwrite that result.
module running_average_window_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rav_pkg::OP_W-1:0]            i_op,
    input  logic signed [rav_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [rav_pkg::FILL_W-1:0]          i_fill_count,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rav_pkg::SAMPLE_W-1:0] o_average,
    output logic [rav_pkg::CNT_W-1:0]           o_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rav_pkg::CFG_W-1:0]           i_window_size
);

    logic [rav_pkg::CFG_W-1:0]    r_window_size;
    logic                         w_fr_valid;
    logic                         w_fr_ready;
    rav_pkg::t_cmd                w_fr_cmd;
    logic                         w_q_valid;
    logic                         w_q_ready;
    rav_pkg::t_cmd                w_q_cmd;
    rav_pkg::t_div_req            w_div_req;
    rav_pkg::t_div_rsp            w_div_rsp;
    logic [rav_pkg::SAMPLE_W-1:0] w_average;

    assign o_cfg_ready = 1'b1;
    assign o_average   = w_average;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= rav_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_size <= i_window_size;
        end
    end

    rav_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_sample     (i_sample),
        .i_fill_count (i_fill_count),
        .o_cmd_valid  (w_fr_valid),
        .i_cmd_ready  (w_fr_ready),
        .o_cmd        (w_fr_cmd)
    );

    rav_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fr_valid),
        .o_push_ready (w_fr_ready),
        .i_push_cmd   (w_fr_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    rav_exec u_exec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_q_valid),
        .o_cmd_ready   (w_q_ready),
        .i_cmd         (w_q_cmd),
        .i_window_size (r_window_size),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_average     (w_average),
        .o_count       (o_count)
    );

    rav_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

/* rtl/rav_checker.sv */
// Port-level checks on the running average window block, bound to the top level.
module rav_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [rav_pkg::SAMPLE_W-1:0] o_average,
    input logic [rav_pkg::CNT_W-1:0]           o_count
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average) && $stable(o_count))
        else $error("result changed while stalled");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count <= rav_pkg::CNT_W'(rav_pkg::WINDOW_MAX))
        else $error("count above window depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_count == '0 |-> o_average == '0)
        else $error("nonzero average on empty window");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

endmodule

bind running_average_window_core rav_checker u_rav_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_average (o_average),
    .o_count   (o_count)
);
